@@ rtl/eight_lane_led_pulse_serializer_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the eight-lane LED pulse serializer
// Simulation builds get concurrent assertions; synthesis builds get nothing.
// ---------------------------------------------------------------------------
`ifndef EIGHT_LANE_LED_PULSE_SERIALIZER_MACROS_SVH
`define EIGHT_LANE_LED_PULSE_SERIALIZER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define ELPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("elps assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define ELPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("elps assertion failed");

`else

`define ELPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ELPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/elps_pkg.sv @@
// ---------------------------------------------------------------------------
// elps_pkg
// Shared widths, codes and reset values of the LED pulse serializer.
// ---------------------------------------------------------------------------
package elps_pkg;

  // Fixed widths of the channel fields.
  localparam int unsigned WORD_W    = 24;
  localparam int unsigned IN_LANES  = 8;
  localparam int unsigned PIN_W     = 8;
  localparam int unsigned TIME_W    = 10;
  localparam int unsigned LATCH_W   = 16;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 4;

  // Operation codes of the input word.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Register map, one register every four bytes.
  typedef enum logic [1:0] {
    REG_ZERO_HIGH  = 2'd0,
    REG_ONE_HIGH   = 2'd1,
    REG_BIT_PERIOD = 2'd2,
    REG_LATCH      = 2'd3
  } cfg_reg_t;

  // Register reset values.
  localparam logic [TIME_W-1:0]  ZERO_HIGH_RST  = 10'd40;
  localparam logic [TIME_W-1:0]  ONE_HIGH_RST   = 10'd80;
  localparam logic [TIME_W-1:0]  BIT_PERIOD_RST = 10'd125;
  localparam logic [LATCH_W-1:0] LATCH_RST      = 16'd580;

endpackage

@@ rtl/elps_in_if.sv @@
// ---------------------------------------------------------------------------
// elps_in_if
// Input channel: one tick or one pixel-group load per word.
// ---------------------------------------------------------------------------
interface elps_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [elps_pkg::WORD_W-1:0]  lane0_word;
  logic [elps_pkg::WORD_W-1:0]  lane1_word;
  logic [elps_pkg::WORD_W-1:0]  lane2_word;
  logic [elps_pkg::WORD_W-1:0]  lane3_word;
  logic [elps_pkg::WORD_W-1:0]  lane4_word;
  logic [elps_pkg::WORD_W-1:0]  lane5_word;
  logic [elps_pkg::WORD_W-1:0]  lane6_word;
  logic [elps_pkg::WORD_W-1:0]  lane7_word;
  logic                         frame_last;

  modport source (
    output valid, op, lane0_word, lane1_word, lane2_word, lane3_word,
           lane4_word, lane5_word, lane6_word, lane7_word, frame_last,
    input  ready
  );

  modport sink (
    input  valid, op, lane0_word, lane1_word, lane2_word, lane3_word,
           lane4_word, lane5_word, lane6_word, lane7_word, frame_last,
    output ready
  );
endinterface

@@ rtl/elps_out_if.sv @@
// ---------------------------------------------------------------------------
// elps_out_if
// Result channel: line levels and status after each input word.
// ---------------------------------------------------------------------------
interface elps_out_if;
  logic                        valid;
  logic                        ready;
  logic [elps_pkg::PIN_W-1:0]  pin_levels;
  logic                        busy_res;
  logic                        can_load;
  logic                        overrun;
  logic                        frame_done;

  modport source (
    output valid, pin_levels, busy_res, can_load, overrun, frame_done,
    input  ready
  );

  modport sink (
    input  valid, pin_levels, busy_res, can_load, overrun, frame_done,
    output ready
  );
endinterface

@@ rtl/eight_lane_led_pulse_serializer.sv @@
// ---------------------------------------------------------------------------
// eight_lane_led_pulse_serializer
// Drives up to eight single-wire LED strips in parallel from pixel groups.
// ---------------------------------------------------------------------------
// Usage:
// The input channel carries one word per cycle. A tick word advances the
// waveform by one time step; a load word offers one pixel group (a word for
// each lane and a frame-last flag) to a one-entry holding buffer. Every
// input word produces exactly one result word on the output channel with
// the lane levels after that word, busy, can_load, overrun and frame_done.
// A word is registered in the input register and its result in the result
// register, so the block takes one word every cycle for as long as the
// receiver keeps up. When the receiver stalls, the result register holds,
// the input register still takes one more word, and then in.ready drops
// until the result is taken. Pulse timing comes from four APB registers;
// the user must write them only while idle, as the block does not check
// it. Reset (synchronous, active low) restores the default timing, empties
// the holding buffer, parks the lanes low and leaves the serializer idle.
// ---------------------------------------------------------------------------
`include "eight_lane_led_pulse_serializer_macros.svh"

module eight_lane_led_pulse_serializer #(
  parameter int unsigned LANES          = 8,
  parameter int unsigned BITS_PER_PIXEL = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  elps_in_if.sink                       in_ch,
  elps_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [elps_pkg::APB_AW-1:0]   paddr,
  input  logic [elps_pkg::APB_DW-1:0]   pwdata,
  output logic [elps_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned BPP = BITS_PER_PIXEL;
  localparam int unsigned BIW = $clog2(BPP);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEND,
    PH_LATCH
  } phase_t;

  typedef logic [BPP-1:0] word_t;

  // ------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------
  logic [elps_pkg::TIME_W-1:0]  zero_high_r;
  logic [elps_pkg::TIME_W-1:0]  one_high_r;
  logic [elps_pkg::TIME_W-1:0]  bit_period_r;
  logic [elps_pkg::LATCH_W-1:0] latch_r;
  logic                         cfg_wr;
  elps_pkg::cfg_reg_t           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = elps_pkg::cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_high_r  <= elps_pkg::ZERO_HIGH_RST;
      one_high_r   <= elps_pkg::ONE_HIGH_RST;
      bit_period_r <= elps_pkg::BIT_PERIOD_RST;
      latch_r      <= elps_pkg::LATCH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        elps_pkg::REG_ZERO_HIGH:  zero_high_r  <= pwdata[elps_pkg::TIME_W-1:0];
        elps_pkg::REG_ONE_HIGH:   one_high_r   <= pwdata[elps_pkg::TIME_W-1:0];
        elps_pkg::REG_BIT_PERIOD: bit_period_r <= pwdata[elps_pkg::TIME_W-1:0];
        elps_pkg::REG_LATCH:      latch_r      <= pwdata[elps_pkg::LATCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      elps_pkg::REG_ZERO_HIGH:  prdata = elps_pkg::APB_DW'(zero_high_r);
      elps_pkg::REG_ONE_HIGH:   prdata = elps_pkg::APB_DW'(one_high_r);
      elps_pkg::REG_BIT_PERIOD: prdata = elps_pkg::APB_DW'(bit_period_r);
      elps_pkg::REG_LATCH:      prdata = elps_pkg::APB_DW'(latch_r);
      default:                  prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Input register and handshake. The word in the input register is
  // processed whenever the result register is free or being emptied.
  // ------------------------------------------------------------------
  logic                        in_valid_r;
  logic                        in_op_r;
  logic                        in_last_r;
  logic [elps_pkg::WORD_W-1:0] in_words_r [elps_pkg::IN_LANES];
  logic                        out_valid_r;
  logic                        proc;

  assign proc        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_op_r       <= in_ch.op;
      in_last_r     <= in_ch.frame_last;
      in_words_r[0] <= in_ch.lane0_word;
      in_words_r[1] <= in_ch.lane1_word;
      in_words_r[2] <= in_ch.lane2_word;
      in_words_r[3] <= in_ch.lane3_word;
      in_words_r[4] <= in_ch.lane4_word;
      in_words_r[5] <= in_ch.lane5_word;
      in_words_r[6] <= in_ch.lane6_word;
      in_words_r[7] <= in_ch.lane7_word;
    end
  end

  // ------------------------------------------------------------------
  // Serializer state.
  // ------------------------------------------------------------------
  phase_t                      phase_r,        phase_nxt;
  logic                        held_valid_r,   held_valid_nxt;
  logic                        held_last_r,    held_last_nxt;
  logic                        sending_last_r, sending_last_nxt;
  logic [BIW-1:0]              bit_idx_r,      bit_idx_nxt;
  logic [elps_pkg::LATCH_W-1:0] tick_cnt_r,    tick_cnt_nxt;
  logic [elps_pkg::PIN_W-1:0]  pin_r,          pin_nxt;
  word_t                       shift_r [LANES];
  word_t                       shift_nxt [LANES];
  word_t                       held_r [LANES];
  word_t                       held_nxt [LANES];
  word_t                       load_words [LANES];

  // Lanes without an input field always carry zeros.
  for (genvar k = 0; k < LANES; k++) begin : g_load
    if (k < elps_pkg::IN_LANES) begin : g_fed
      assign load_words[k] = BPP'(in_words_r[k]);
    end else begin : g_zero
      assign load_words[k] = '0;
    end
  end

  // A tick that finds the serializer idle with a group held starts that
  // group on the same tick, so the tick works on the started state.
  logic                         start_now;
  phase_t                       phase_e;
  logic                         held_valid_e;
  logic                         sending_last_e;
  logic [BIW-1:0]               bit_idx_e;
  logic [elps_pkg::LATCH_W-1:0] tick_cnt_e;
  logic [elps_pkg::LATCH_W-1:0] tick_inc;
  logic [elps_pkg::LATCH_W-1:0] period_len;
  logic [elps_pkg::LATCH_W-1:0] latch_len;
  word_t                        shift_e [LANES];
  logic [LANES-1:0]             lane_lv;
  logic [elps_pkg::PIN_W-1:0]   pin_lv;
  logic                         res_overrun;
  logic                         res_done;

  assign start_now      = (in_op_r == elps_pkg::OP_TICK) && (phase_r == PH_IDLE)
                          && held_valid_r;
  assign phase_e        = start_now ? PH_SEND : phase_r;
  assign held_valid_e   = start_now ? 1'b0 : held_valid_r;
  assign sending_last_e = start_now ? held_last_r : sending_last_r;
  assign bit_idx_e      = start_now ? '0 : bit_idx_r;
  assign tick_cnt_e     = start_now ? '0 : tick_cnt_r;
  assign tick_inc       = tick_cnt_e + elps_pkg::LATCH_W'(1);

  // A zero period or latch length behaves as one tick.
  assign period_len = (bit_period_r == '0) ? elps_pkg::LATCH_W'(1)
                                           : elps_pkg::LATCH_W'(bit_period_r);
  assign latch_len  = (latch_r == '0) ? elps_pkg::LATCH_W'(1) : latch_r;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      shift_e[k] = start_now ? held_r[k] : shift_r[k];
      lane_lv[k] = (tick_cnt_e < elps_pkg::LATCH_W'(one_high_r))
                   && (shift_e[k][BPP-1]
                       || (tick_cnt_e < elps_pkg::LATCH_W'(zero_high_r)));
    end
  end

  for (genvar p = 0; p < elps_pkg::PIN_W; p++) begin : g_pin
    if (p < LANES) begin : g_lane
      assign pin_lv[p] = lane_lv[p];
    end else begin : g_none
      assign pin_lv[p] = 1'b0;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    held_valid_nxt   = held_valid_r;
    held_last_nxt    = held_last_r;
    sending_last_nxt = sending_last_r;
    bit_idx_nxt      = bit_idx_r;
    tick_cnt_nxt     = tick_cnt_r;
    pin_nxt          = pin_r;
    shift_nxt        = shift_r;
    held_nxt         = held_r;
    res_overrun      = 1'b0;
    res_done         = 1'b0;

    if (in_op_r == elps_pkg::OP_LOAD) begin
      // Loads do not move time; a full buffer refuses the group.
      if (held_valid_r) begin
        res_overrun = 1'b1;
      end else begin
        held_nxt       = load_words;
        held_last_nxt  = in_last_r;
        held_valid_nxt = 1'b1;
      end
    end else begin
      phase_nxt        = phase_e;
      held_valid_nxt   = held_valid_e;
      sending_last_nxt = sending_last_e;
      bit_idx_nxt      = bit_idx_e;
      tick_cnt_nxt     = tick_cnt_e;
      shift_nxt        = shift_e;
      unique case (phase_e)
        PH_SEND: begin
          pin_nxt = pin_lv;
          if (tick_inc >= period_len) begin
            tick_cnt_nxt = '0;
            if (bit_idx_e == BIW'(BPP - 1)) begin
              // Group finished: chain the next one, latch, or go idle.
              bit_idx_nxt = '0;
              if (held_valid_e) begin
                shift_nxt        = held_r;
                sending_last_nxt = held_last_r;
                held_valid_nxt   = 1'b0;
                phase_nxt        = PH_SEND;
              end else if (sending_last_e) begin
                phase_nxt = PH_LATCH;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end else begin
              bit_idx_nxt = bit_idx_e + BIW'(1);
              for (int k = 0; k < LANES; k++) begin
                shift_nxt[k] = {shift_e[k][BPP-2:0], 1'b0};
              end
            end
          end else begin
            tick_cnt_nxt = tick_inc;
          end
        end
        PH_LATCH: begin
          pin_nxt = '0;
          if (tick_inc >= latch_len) begin
            tick_cnt_nxt = '0;
            res_done     = 1'b1;
            phase_nxt    = PH_IDLE;
          end else begin
            tick_cnt_nxt = tick_inc;
          end
        end
        default: begin
          pin_nxt = '0;
        end
      endcase
    end
  end

  // ------------------------------------------------------------------
  // State and result registers.
  // ------------------------------------------------------------------
  logic out_busy_r;
  logic out_can_load_r;
  logic out_overrun_r;
  logic out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      held_valid_r   <= 1'b0;
      held_last_r    <= 1'b0;
      sending_last_r <= 1'b0;
      bit_idx_r      <= '0;
      tick_cnt_r     <= '0;
      pin_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (proc) begin
        phase_r        <= phase_nxt;
        held_valid_r   <= held_valid_nxt;
        held_last_r    <= held_last_nxt;
        sending_last_r <= sending_last_nxt;
        bit_idx_r      <= bit_idx_nxt;
        tick_cnt_r     <= tick_cnt_nxt;
        pin_r          <= pin_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      shift_r        <= shift_nxt;
      held_r         <= held_nxt;
      out_busy_r     <= (phase_nxt != PH_IDLE);
      out_can_load_r <= !held_valid_nxt;
      out_overrun_r  <= res_overrun;
      out_done_r     <= res_done;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pin_levels = pin_r;
  assign out_ch.busy_res   = out_busy_r;
  assign out_ch.can_load   = out_can_load_r;
  assign out_ch.overrun    = out_overrun_r;
  assign out_ch.frame_done = out_done_r;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  `ELPS_ASSERT_IMPLY(a_done_not_busy, clk, rst_n, out_valid_r && out_done_r, !out_busy_r)
  `ELPS_ASSERT_IMPLY(a_overrun_full, clk, rst_n, out_valid_r && out_overrun_r,
                     !out_can_load_r)
  `ELPS_ASSERT_NEXT(a_full_load_refused, clk, rst_n,
                    proc && (in_op_r == elps_pkg::OP_LOAD) && held_valid_r,
                    out_valid_r && out_overrun_r)
  `ELPS_ASSERT_IMPLY(a_idle_counters_clear, clk, rst_n, phase_r == PH_IDLE,
                     (tick_cnt_r == '0) && (bit_idx_r == '0))

endmodule
